[sv/positional_list_engine_macros.svh]
// Assertion helpers shared by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PLE_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLE_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[sv/ple_pkg.sv]
package ple_pkg;

  localparam int unsigned DEPTH_DEF = 64;

  localparam logic [2:0] OP_ADD_FRONT = 3'd0;
  localparam logic [2:0] OP_ADD_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT_AT = 3'd2;
  localparam logic [2:0] OP_DEL_FRONT = 3'd3;
  localparam logic [2:0] OP_DEL_BACK  = 3'd4;
  localparam logic [2:0] OP_DEL_AT    = 3'd5;
  localparam logic [2:0] OP_READ_AT   = 3'd6;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  localparam logic signed [31:0] MIN_VALUE = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         position;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         entry_count;
  } out_rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               ins;
    logic               del;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

[sv/ple_cell.sv]
module ple_cell #(
  parameter int unsigned AW  = 6,
  parameter int unsigned IDX = 0
) (
  input  logic                    clk,
  input  ple_pkg::cell_ctl_t      ctl_i,
  input  logic [AW-1:0]           slot_i,
  input  logic signed [31:0]      left_i,
  input  logic signed [31:0]      right_i,
  output logic signed [31:0]      data_o,
  output logic signed [31:0]      rd_o
);

  localparam logic [AW-1:0] MY_IDX = AW'(IDX);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl_i.ins) begin
      if (MY_IDX == slot_i) begin
        data_nxt = ctl_i.value;
      end else if (MY_IDX > slot_i) begin
        data_nxt = left_i;
      end
    end else if (ctl_i.del) begin
      if (MY_IDX >= slot_i) begin
        data_nxt = right_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  // one-hot select term, OR-combined at the top
  assign rd_o   = (MY_IDX == slot_i) ? data_r : '0;

endmodule

[sv/positional_list_engine.sv]
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of cells, one entry per
// cell. Requests are add front/back, insert at, delete front/back/at and read at: an
// insert shifts all cells at or after the slot one place toward the tail, a delete
// one place toward the head, both in the cycle the request is accepted, and a read selects
// the addressed cell. One response per request is registered at the output; a new request is
// taken in the same cycle the pending response is taken, so while out_ready holds high
// sustained throughput is one request per clock. Positions are 1-based; bad positions,
// full inserts and empty deletes leave the list unchanged and are flagged in status.
`include "positional_list_engine_macros.svh"

module positional_list_engine #(
  parameter int unsigned DEPTH = ple_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::out_rsp_t out_rsp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = ((CW > 7) ? CW : 7) + 1;

  logic [CW-1:0]      count_r, count_nxt;
  logic               out_valid_r;
  ple_pkg::out_rsp_t  out_rsp_r;
  ple_pkg::out_rsp_t  rsp_nxt;

  logic               in_acc;
  logic               ins_go, del_go;
  logic [PW-1:0]      pos_w, cnt_w, slot_w;
  logic               pos_zero, pos_gt_c, pos_gt_c1, full, empty;
  logic [1:0]         st;
  logic signed [31:0] rv;
  logic signed [31:0] rd_any;
  logic [31:0]        cnt_ext;

  ple_pkg::cell_ctl_t ctl;
  logic signed [31:0] cell_data [DEPTH];
  logic signed [31:0] cell_rd   [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign pos_w     = PW'(in_req.position);
  assign cnt_w     = PW'(count_r);
  assign pos_zero  = (pos_w == '0);
  assign pos_gt_c  = (pos_w > cnt_w);
  assign pos_gt_c1 = (pos_w > (cnt_w + PW'(1)));
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    ins_go = 1'b0;
    del_go = 1'b0;
    slot_w = pos_w - PW'(1);
    st     = ple_pkg::ST_DONE;
    rv     = '0;
    case (in_req.opcode)
      ple_pkg::OP_ADD_FRONT: begin
        slot_w = '0;
        if (full) st = ple_pkg::ST_FULL;
        else ins_go = 1'b1;
      end
      ple_pkg::OP_ADD_BACK: begin
        slot_w = cnt_w;
        if (full) st = ple_pkg::ST_FULL;
        else ins_go = 1'b1;
      end
      ple_pkg::OP_INSERT_AT: begin
        if (pos_zero || pos_gt_c1) st = ple_pkg::ST_BADPOS;
        else if (full) st = ple_pkg::ST_FULL;
        else ins_go = 1'b1;
      end
      ple_pkg::OP_DEL_FRONT: begin
        slot_w = '0;
        if (empty) st = ple_pkg::ST_EMPTY;
        else del_go = 1'b1;
      end
      ple_pkg::OP_DEL_BACK: begin
        slot_w = cnt_w - PW'(1);
        if (empty) st = ple_pkg::ST_EMPTY;
        else del_go = 1'b1;
      end
      ple_pkg::OP_DEL_AT: begin
        if (empty) st = ple_pkg::ST_EMPTY;
        else if (pos_zero || pos_gt_c) st = ple_pkg::ST_BADPOS;
        else del_go = 1'b1;
      end
      ple_pkg::OP_READ_AT: begin
        if (pos_zero || pos_gt_c) begin
          st = ple_pkg::ST_BADPOS;
          rv = ple_pkg::MIN_VALUE;
        end else begin
          rv = rd_any;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (in_acc && ins_go) count_nxt = count_r + CW'(1);
    else if (in_acc && del_go) count_nxt = count_r - CW'(1);
  end

  assign cnt_ext = 32'(count_nxt);

  always_comb begin
    rsp_nxt.read_value  = rv;
    rsp_nxt.status      = st;
    rsp_nxt.entry_count = cnt_ext[6:0];
  end

  assign ctl.ins   = in_acc && ins_go;
  assign ctl.del   = in_acc && del_go;
  assign ctl.value = in_req.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ple_cell #(
      .AW  (AW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .slot_i  (slot_w[AW-1:0]),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_acc) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_rsp_r <= rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `PLE_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "count above depth")
  `PLE_ASSERT_NEXT(a_rsp_follows, clk, rst_n, in_acc, out_valid_r, "request without response")
  `PLE_ASSERT_NEXT(a_ins_count, clk, rst_n, in_acc && ins_go,
    count_r == CW'($past(count_r) + CW'(1)), "insert did not grow list")
  `PLE_ASSERT_NOW(a_full_status, clk, rst_n, in_acc && st == ple_pkg::ST_FULL, full,
    "full status on non-full list")
  `PLE_ASSERT_NOW(a_one_move, clk, rst_n, 1'b1, !(ctl.ins && ctl.del), "insert and delete together")

endmodule

[tb/positional_list_engine_tb.sv]
`timescale 1ns / 100ps

module positional_list_engine_tb;

  localparam int unsigned LIST_DEPTH  = ple_pkg::DEPTH_DEF;
  localparam logic [2:0]  OP_NOP      = 3'd7;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          PRINT_CAP   = 60;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ple_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ple_pkg::out_rsp_t out_rsp;

  // Shadow of the list contents and the responses still owed by the block.
  logic signed [31:0] list_shadow[$];
  ple_pkg::out_rsp_t  rsp_pending[$];
  ple_pkg::out_rsp_t  rsp_want;

  int err_count  = 0;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int rx_tick    = 0;
  int rx_mode    = 0;

  positional_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (err_count < PRINT_CAP) begin
      $display("ERROR cycle %0d: %s", cycle_cnt, what);
    end
    err_count++;
  endtask

  // Applies one request to the shadow list and returns the response it owes.
  function automatic ple_pkg::out_rsp_t apply_list_op(input ple_pkg::in_req_t r);
    ple_pkg::out_rsp_t rsp;
    int unsigned       cnt;
    int unsigned       pos;
    rsp = '0;
    rsp.status = ple_pkg::ST_DONE;
    cnt = list_shadow.size();
    pos = r.position;
    case (r.opcode)
      ple_pkg::OP_ADD_FRONT, ple_pkg::OP_ADD_BACK: begin
        if (cnt >= LIST_DEPTH) begin
          rsp.status = ple_pkg::ST_FULL;
        end else if (r.opcode == ple_pkg::OP_ADD_FRONT) begin
          list_shadow.push_front(r.value);
        end else begin
          list_shadow.push_back(r.value);
        end
      end
      ple_pkg::OP_INSERT_AT: begin
        // bad position wins over full
        if (pos == 0 || pos > cnt + 1) begin
          rsp.status = ple_pkg::ST_BADPOS;
        end else if (cnt >= LIST_DEPTH) begin
          rsp.status = ple_pkg::ST_FULL;
        end else begin
          list_shadow.insert(pos - 1, r.value);
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK: begin
        if (cnt == 0) begin
          rsp.status = ple_pkg::ST_EMPTY;
        end else if (r.opcode == ple_pkg::OP_DEL_FRONT) begin
          void'(list_shadow.pop_front());
        end else begin
          void'(list_shadow.pop_back());
        end
      end
      ple_pkg::OP_DEL_AT: begin
        if (cnt == 0) begin
          rsp.status = ple_pkg::ST_EMPTY;
        end else if (pos == 0 || pos > cnt) begin
          rsp.status = ple_pkg::ST_BADPOS;
        end else begin
          list_shadow.delete(pos - 1);
        end
      end
      ple_pkg::OP_READ_AT: begin
        if (pos == 0 || pos > cnt) begin
          rsp.status     = ple_pkg::ST_BADPOS;
          rsp.read_value = ple_pkg::MIN_VALUE;
        end else begin
          rsp.read_value = list_shadow[pos - 1];
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count = 7'(list_shadow.size());
    return rsp;
  endfunction

  // Sends one request; idles between bursts of random length.
  task automatic send_req(input logic [2:0] op, input logic [6:0] pos,
                          input logic signed [31:0] val);
    ple_pkg::in_req_t r;
    int               gap;
    r.opcode   = op;
    r.position = pos;
    r.value    = val;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp_pending.push_back(apply_list_op(r));
    burst_left--;
  endtask

  // Holds off new requests until the block has answered everything.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (rsp_pending.size() != 0);
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return ple_pkg::MIN_VALUE;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, with edges and stray values mixed in.
  function automatic logic [6:0] rand_pos(input int unsigned limit);
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'(limit + 1);
      2:       return 7'($urandom_range(0, 127));
      3:       return (limit > 0) ? 7'(limit) : 7'd1;
      default: return 7'($urandom_range(1, (limit > 0) ? limit : 1));
    endcase
  endfunction

  task automatic test_empty_list();
    send_req(ple_pkg::OP_DEL_FRONT, 7'd0,   32'sd0);
    send_req(ple_pkg::OP_DEL_BACK,  7'd0,   32'sd0);
    send_req(ple_pkg::OP_DEL_AT,    7'd1,   32'sd0);
    send_req(ple_pkg::OP_DEL_AT,    7'd0,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd0,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd1,   32'sd0);
    send_req(ple_pkg::OP_INSERT_AT, 7'd0,   32'sd5);
    send_req(ple_pkg::OP_INSERT_AT, 7'd2,   32'sd5);
    send_req(OP_NOP,                7'd127, -32'sd1);
  endtask

  task automatic test_edge_values();
    send_req(ple_pkg::OP_INSERT_AT, 7'd1,   32'sh7fff_ffff);
    send_req(ple_pkg::OP_ADD_FRONT, 7'd0,   ple_pkg::MIN_VALUE);
    send_req(ple_pkg::OP_ADD_BACK,  7'd0,   32'sd0);
    send_req(ple_pkg::OP_INSERT_AT, 7'd4,   -32'sd1);   // count+1 appends
    send_req(ple_pkg::OP_INSERT_AT, 7'd2,   32'sh5555_5555);
    send_req(ple_pkg::OP_READ_AT,   7'd1,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd5,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd6,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd127, 32'sd0);
    send_req(ple_pkg::OP_DEL_AT,    7'd6,   32'sd0);
    send_req(ple_pkg::OP_DEL_AT,    7'd0,   32'sd0);
    send_req(ple_pkg::OP_DEL_AT,    7'd3,   32'sd0);
    send_req(ple_pkg::OP_DEL_FRONT, 7'd0,   32'sd0);
    send_req(ple_pkg::OP_DEL_BACK,  7'd0,   32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd2,   32'sd0);
  endtask

  task automatic test_fill_to_full();
    int unsigned cnt;
    while (list_shadow.size() < LIST_DEPTH) begin
      cnt = list_shadow.size();
      case ($urandom_range(0, 2))
        0:       send_req(ple_pkg::OP_ADD_FRONT, 7'($urandom), rand_value());
        1:       send_req(ple_pkg::OP_ADD_BACK, 7'($urandom), rand_value());
        default: send_req(ple_pkg::OP_INSERT_AT, 7'($urandom_range(1, cnt + 1)),
                          rand_value());
      endcase
    end
    send_req(ple_pkg::OP_ADD_FRONT, 7'd0, rand_value());
    send_req(ple_pkg::OP_ADD_BACK,  7'd0, rand_value());
    send_req(ple_pkg::OP_INSERT_AT, 7'($urandom_range(1, LIST_DEPTH + 1)), rand_value());
    send_req(ple_pkg::OP_INSERT_AT, 7'(LIST_DEPTH + 2), rand_value());
    send_req(ple_pkg::OP_INSERT_AT, 7'd0, rand_value());
    send_req(ple_pkg::OP_READ_AT,   7'(LIST_DEPTH), 32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'(LIST_DEPTH + 1), 32'sd0);
    send_req(ple_pkg::OP_READ_AT,   7'd1, 32'sd0);
    wait_idle();
  endtask

  task automatic test_empty_out();
    int unsigned cnt;
    while (list_shadow.size() > 0) begin
      cnt = list_shadow.size();
      case ($urandom_range(0, 4))
        0:       send_req(ple_pkg::OP_DEL_FRONT, 7'($urandom), rand_value());
        1:       send_req(ple_pkg::OP_DEL_BACK, 7'($urandom), rand_value());
        2:       send_req(ple_pkg::OP_READ_AT, rand_pos(cnt), rand_value());
        default: send_req(ple_pkg::OP_DEL_AT, 7'($urandom_range(1, cnt)), rand_value());
      endcase
    end
    send_req(ple_pkg::OP_DEL_AT,    7'($urandom), rand_value());
    send_req(ple_pkg::OP_DEL_FRONT, 7'($urandom), rand_value());
    send_req(ple_pkg::OP_READ_AT,   7'd1, rand_value());
  endtask

  task automatic test_random_mix(input int n_items);
    int          w;
    int unsigned cnt;
    bit          grow;
    logic [2:0]  op;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      if (i % 120 == 0) grow = ~grow;
      cnt = list_shadow.size();
      w   = $urandom_range(0, 99);
      if (grow) begin
        op = (w < 20) ? ple_pkg::OP_ADD_FRONT : (w < 40) ? ple_pkg::OP_ADD_BACK :
             (w < 60) ? ple_pkg::OP_INSERT_AT : (w < 68) ? ple_pkg::OP_DEL_FRONT :
             (w < 76) ? ple_pkg::OP_DEL_BACK  : (w < 84) ? ple_pkg::OP_DEL_AT :
             (w < 98) ? ple_pkg::OP_READ_AT   : OP_NOP;
      end else begin
        op = (w < 10) ? ple_pkg::OP_ADD_FRONT : (w < 20) ? ple_pkg::OP_ADD_BACK :
             (w < 30) ? ple_pkg::OP_INSERT_AT : (w < 50) ? ple_pkg::OP_DEL_FRONT :
             (w < 70) ? ple_pkg::OP_DEL_BACK  : (w < 85) ? ple_pkg::OP_DEL_AT :
             (w < 98) ? ple_pkg::OP_READ_AT   : OP_NOP;
      end
      send_req(op, rand_pos((op == ple_pkg::OP_INSERT_AT) ? cnt + 1 : cnt), rand_value());
      if (i == n_items / 2) wait_idle();
    end
  endtask

  // Response side: stall pattern plus in-order compare.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (rsp_pending.size() == 0) begin
        report_mismatch("response with no request pending");
      end else begin
        rsp_want = rsp_pending.pop_front();
        if (out_rsp.read_value !== rsp_want.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    out_rsp.read_value, rsp_want.read_value));
        if (out_rsp.status !== rsp_want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_rsp.status, rsp_want.status));
        if (out_rsp.entry_count !== rsp_want.entry_count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    out_rsp.entry_count, rsp_want.entry_count));
      end
    end
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= 1'($urandom_range(0, 1));
      2:       out_ready <= (rx_tick % 4 != 3);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_edge_values();
    repeat (3) begin
      test_fill_to_full();
      test_empty_out();
    end
    test_random_mix(900);
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
